[rtl/cssc_pkg.sv]
// ============================================================================
// cssc_pkg
// Types, character codes and scan helpers for the comment strip unit.
// ============================================================================
package cssc_pkg;

    localparam int unsigned BYTE_W = 8;

    // tuser bit positions on the result channel
    localparam int unsigned USER_BYTE_VALID = 0;
    localparam int unsigned USER_UNTERM     = 1;
    localparam int unsigned USER_W          = 2;

    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

    typedef enum logic [5:0] {
        MODE_NORMAL     = 6'b000001,
        MODE_SLASH      = 6'b000010,
        MODE_SPACE      = 6'b000100,
        MODE_LINE       = 6'b001000,
        MODE_BLOCK      = 6'b010000,
        MODE_BLOCK_STAR = 6'b100000
    } scan_mode_t;

    typedef struct packed {
        scan_mode_t mode;
        logic       last_was_space;
        logic       in_space_run;
    } scan_state_t;

    // up to two bytes produced by one input byte
    typedef struct packed {
        logic [1:0]        cnt;
        logic [BYTE_W-1:0] b0;
        logic [BYTE_W-1:0] b1;
    } res_set_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              byte_valid;
        logic              eot;
        logic              unterm;
    } res_entry_t;

    function automatic logic is_ws(input logic [BYTE_W-1:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    // append a byte; anything beyond two is dropped
    function automatic void put_byte(inout res_set_t r, input logic [BYTE_W-1:0] b);
        if (r.cnt == 2'd0) begin
            r.b0  = b;
            r.cnt = 2'd1;
        end else if (r.cnt == 2'd1) begin
            r.b1  = b;
            r.cnt = 2'd2;
        end
    endfunction

    function automatic void space_byte(inout scan_state_t s, inout res_set_t r,
                                       input logic [BYTE_W-1:0] b);
        if (b == CH_LF) begin
            if (s.in_space_run && !s.last_was_space) begin
                put_byte(r, CH_SPACE);
            end
            put_byte(r, CH_LF);
            s.in_space_run   = 1'b0;
            s.last_was_space = 1'b0;
        end else begin
            s.in_space_run = 1'b1;
        end
    endfunction

    function automatic void close_run(inout scan_state_t s, inout res_set_t r);
        if (s.in_space_run && !s.last_was_space) begin
            put_byte(r, CH_SPACE);
        end
        s.in_space_run   = 1'b0;
        s.last_was_space = 1'b1;
        s.mode           = MODE_NORMAL;
    endfunction

    function automatic void plain(inout scan_state_t s, inout res_set_t r,
                                  input logic [BYTE_W-1:0] b);
        if (b == CH_SLASH) begin
            s.mode = MODE_SLASH;
        end else if (is_ws(b)) begin
            s.mode         = MODE_SPACE;
            s.in_space_run = 1'b0;
            space_byte(s, r, b);
        end else begin
            s.mode = MODE_NORMAL;
            put_byte(r, b);
            s.last_was_space = 1'b0;
        end
    endfunction

endpackage

[rtl/comment_strip_space_collapse_unit.sv]
// ============================================================================
// comment_strip_space_collapse_unit
// Streams source text, removes C comments and collapses whitespace.
// ============================================================================
// Usage:
//  - s_ channel: one text byte per transfer in s_tdata, s_tlast on the final
//    byte of a text. s_tready is high while the result queue holds at most
//    one entry, so a byte is taken every cycle while the receiver keeps up.
//  - m_ channel: one output byte per transfer. m_tuser[0] says m_tdata holds
//    a byte (0 only for a bare end marker), m_tuser[1] flags a text that ended
//    inside a block comment, m_tlast marks the last result of a text.
//  - Results: each result is registered in the result queue and shows on m_ from its head.
//  - Throughput: one byte per cycle while s_tready is high. A byte that
//    yields two results (a flushed slash or space plus a byte) drops s_tready
//    until the queue is down to one entry. Bytes inside comments yield nothing.
//  - The scan state and the 3-entry result queue set this behaviour; all the
//    scan logic sits between the s_ port and the queue registers.
//  - Reset (aresetn low, synchronous) empties the queue and returns the
//    scanner to normal mode. Each text end also returns it there.
//  - A stalled receiver holds m_ steady; the queue fills and drops s_tready.
// ============================================================================
module comment_strip_space_collapse_unit (
    input  logic       aclk,
    input  logic       aresetn,
    // s_tdata: [7:0] in_byte
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       s_tvalid,
    output logic       s_tready,
    // m_tdata: [7:0] out_byte
    output logic [7:0] m_tdata,
    // m_tuser: [0] byte_valid, [1] unterminated_comment
    output logic [1:0] m_tuser,
    output logic       m_tlast,
    output logic       m_tvalid,
    input  logic       m_tready
);
    import cssc_pkg::*;

    localparam int unsigned QDEPTH = 3;

    scan_state_t state_reg, state_next;
    res_entry_t  q_reg  [QDEPTH];
    res_entry_t  q_next [QDEPTH];
    logic [1:0]  count_reg, count_next;

    logic        in_xfer, out_xfer;
    res_set_t    res;
    logic        unterm;
    res_entry_t  ent0, ent1;
    logic [1:0]  push_cnt;
    logic [1:0]  wr_idx;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;
    assign s_tready = !count_reg[1];
    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = q_reg[0].data;
    assign m_tlast  = q_reg[0].eot;
    assign m_tuser  = {q_reg[0].unterm, q_reg[0].byte_valid};

    // ---- scanner: one input byte -> up to two results
    always_comb begin
        scan_state_t s;
        res_set_t    r;
        logic        ut;
        s      = state_reg;
        r      = '0;
        ut     = 1'b0;
        unique case (s.mode)
            MODE_SLASH: begin
                if (s_tdata == CH_SLASH) begin
                    if (!s.last_was_space) put_byte(r, CH_SPACE);
                    s.last_was_space = 1'b0;
                    s.mode           = MODE_LINE;
                end else if (s_tdata == CH_STAR) begin
                    if (!s.last_was_space) put_byte(r, CH_SPACE);
                    s.last_was_space = 1'b1;
                    s.mode           = MODE_BLOCK;
                end else begin
                    put_byte(r, CH_SLASH);
                    s.last_was_space = 1'b0;
                    s.mode           = MODE_NORMAL;
                    plain(s, r, s_tdata);
                end
            end
            MODE_SPACE: begin
                if (is_ws(s_tdata)) begin
                    space_byte(s, r, s_tdata);
                end else begin
                    close_run(s, r);
                    plain(s, r, s_tdata);
                end
            end
            MODE_LINE: begin
                if (s_tdata == CH_LF) begin
                    put_byte(r, CH_LF);
                    s.last_was_space = 1'b0;
                    s.mode           = MODE_NORMAL;
                end
            end
            MODE_BLOCK: begin
                if (s_tdata == CH_STAR) s.mode = MODE_BLOCK_STAR;
            end
            MODE_BLOCK_STAR: begin
                if (s_tdata == CH_SLASH) begin
                    s.mode = MODE_NORMAL;
                end else if (s_tdata != CH_STAR) begin
                    s.mode = MODE_BLOCK;
                end
            end
            default: begin
                s.mode = MODE_NORMAL;
                plain(s, r, s_tdata);
            end
        endcase

        // end of text: flush pending slash or space, flag open block comment
        if (s_tlast) begin
            unique case (s.mode)
                MODE_SLASH:                 put_byte(r, CH_SLASH);
                MODE_SPACE:                 close_run(s, r);
                MODE_BLOCK, MODE_BLOCK_STAR: ut = 1'b1;
                default:                    ;
            endcase
            s.mode           = MODE_NORMAL;
            s.last_was_space = 1'b0;
            s.in_space_run   = 1'b0;
        end

        state_next = s;
        res        = r;
        unterm     = ut;
    end

    // ---- build queue entries; end flags go on the last result
    always_comb begin
        ent0 = '{data: res.b0, byte_valid: 1'b1, eot: 1'b0, unterm: 1'b0};
        ent1 = '{data: res.b1, byte_valid: 1'b1, eot: 1'b0, unterm: 1'b0};
        push_cnt = res.cnt;
        if (s_tlast) begin
            priority if (res.cnt == 2'd0) begin
                // bare end marker
                ent0     = '{data: '0, byte_valid: 1'b0, eot: 1'b1, unterm: unterm};
                push_cnt = 2'd1;
            end else if (res.cnt == 2'd1) begin
                ent0.eot    = 1'b1;
                ent0.unterm = unterm;
            end else begin
                ent1.eot    = 1'b1;
                ent1.unterm = unterm;
            end
        end
        if (!in_xfer) push_cnt = 2'd0;
    end

    // ---- result queue: pop at head, push behind the survivors
    always_comb begin
        for (int i = 0; i < QDEPTH - 1; i++) begin
            if (out_xfer) q_next[i] = q_reg[i+1];
            else          q_next[i] = q_reg[i];
        end
        q_next[QDEPTH-1] = q_reg[QDEPTH-1];
        wr_idx = count_reg - {1'b0, out_xfer};
        if (push_cnt != 2'd0) q_next[wr_idx] = ent0;
        if (push_cnt == 2'd2) q_next[wr_idx + 2'd1] = ent1;
        count_next = wr_idx + push_cnt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{mode: MODE_NORMAL, last_was_space: 1'b0, in_space_run: 1'b0};
            count_reg <= 2'd0;
        end else begin
            if (in_xfer) state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < QDEPTH; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule

[rtl/cssc_checker.sv]
// ============================================================================
// cssc_checker
// Port-level checks on the result channel of the comment strip unit.
// ============================================================================
module cssc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast,
    input logic       m_tvalid,
    input logic       m_tready
);
    import cssc_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // open-comment flag only rides on the end of a text
    a_unterm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[USER_UNTERM] |-> m_tlast)
        else $error("unterminated flag without end of text");

    // a bare marker is only the end marker and carries zero
    a_bare: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[USER_BYTE_VALID] |-> m_tlast && (m_tdata == 8'h00))
        else $error("bare result that is not an end marker");

    // reset empties the result queue
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind comment_strip_space_collapse_unit cssc_checker u_cssc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
